>>> hdl/assert_macros.svh
// Assertion macros shared by the quantized Hilbert index RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on clk and disabled while rst is high.
`define QHI_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qhi: implication check failed");
// Next-cycle implication, checked on clk and disabled while rst is high.
`define QHI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qhi: next-cycle check failed");
`else
`define QHI_ASSERT_IMPL(lbl, ante, cons)
`define QHI_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> hdl/qhi_pkg.sv
// Shared constants and types for the quantized Hilbert index block.
`default_nettype none
package qhi_pkg;

  localparam int COORD_W          = 32;
  localparam int SCALE_W          = 32;
  localparam int PROD_W           = COORD_W + SCALE_W;
  // Q16.16 times Q16.16 leaves 32 fraction bits in the product.
  localparam int CELL_SHIFT       = 32;
  localparam int HI_W             = PROD_W - CELL_SHIFT;
  localparam int ORDER_CFG_W      = 5;
  localparam int INDEX_W          = 32;
  localparam int DEFAULT_MAX_ORDER = 16;
  localparam int LEVELS_PER_STAGE = 4;
  localparam int QUANT_STAGES     = 3;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [COORD_W-1:0]     X_ORIGIN_RST   = '0;
  localparam logic [COORD_W-1:0]     Y_ORIGIN_RST   = '0;
  localparam logic [SCALE_W-1:0]     X_SCALE_RST    = 32'h0001_0000;
  localparam logic [SCALE_W-1:0]     Y_SCALE_RST    = 32'h0001_0000;
  localparam logic [ORDER_CFG_W-1:0] GRID_ORDER_RST = 5'd1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_X_ORIGIN   = 3'd0,
    REG_Y_ORIGIN   = 3'd1,
    REG_X_SCALE    = 3'd2,
    REG_Y_SCALE    = 3'd3,
    REG_GRID_ORDER = 3'd4
  } reg_index_t;

endpackage
`default_nettype wire

>>> hdl/quantized_hilbert_index.sv
// Top level of the quantized Hilbert index block: config port, stage control, datapath.
//
// Usage: each item on the slave stream is one 2-D point, x in s_tdata[31:0]
// and y in s_tdata[63:32], both signed Q16.16. Each axis has its origin
// subtracted, is scaled by its cells-per-unit factor and is saturated into
// 0 .. 2^order-1; the master stream then returns the Hilbert distance of that
// cell in m_tdata and a saturation flag in m_tuser.
// Throughput is one item per clock while the receiver does not stall. The pipeline
// has 3 + ceil(MAX_ORDER/4) register stages, seven at the default MAX_ORDER of 16:
// three for the quantizers (subtract, multiply, saturate), one per four curve levels.
// Every stage carries its own valid bit and advances when it is empty or when
// the stage after it advances, so bubbles close up. When the receiver stalls,
// the pipeline keeps accepting items until all stages are full, then holds
// s_tready low; nothing is dropped or repeated.
// Reset (rst, synchronous, active high) empties the pipeline and returns the
// registers to origin 0, scale 1.0 and grid order 1.
// The APB registers are meant to be written only while the pipeline is empty.
`default_nettype none
`include "assert_macros.svh"
module quantized_hilbert_index #(
  parameter int MAX_ORDER = qhi_pkg::DEFAULT_MAX_ORDER
) (
  input  logic                          clk,
  input  logic                          rst,
  // Slave stream; s_tdata: x_coord [31:0], y_coord [63:32].
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [2*qhi_pkg::COORD_W-1:0] s_tdata,
  // Master stream; m_tdata: hilbert_index [31:0].
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [qhi_pkg::INDEX_W-1:0]   m_tdata,
  // m_tuser: clamped [0].
  output logic                          m_tuser,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qhi_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [qhi_pkg::APB_DATA_W-1:0] pwdata,
  output logic [qhi_pkg::APB_DATA_W-1:0] prdata,
  output logic                          pready
);
  import qhi_pkg::*;

  localparam int CurveStages = (MAX_ORDER + LEVELS_PER_STAGE - 1) / LEVELS_PER_STAGE;
  localparam int NStages     = QUANT_STAGES + CurveStages;
  localparam int OrderW      = $clog2(MAX_ORDER + 1);
  localparam bit MaxOdd      = (MAX_ORDER % 2) == 1;

  // Configuration registers.
  logic [COORD_W-1:0]     x_origin;
  logic [COORD_W-1:0]     y_origin;
  logic [SCALE_W-1:0]     x_scale;
  logic [SCALE_W-1:0]     y_scale;
  logic [ORDER_CFG_W-1:0] grid_order;

  logic       wr_en;
  reg_index_t reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = reg_index_t'(paddr[APB_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      x_origin   <= X_ORIGIN_RST;
      y_origin   <= Y_ORIGIN_RST;
      x_scale    <= X_SCALE_RST;
      y_scale    <= Y_SCALE_RST;
      grid_order <= GRID_ORDER_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_X_ORIGIN:   x_origin   <= pwdata;
        REG_Y_ORIGIN:   y_origin   <= pwdata;
        REG_X_SCALE:    x_scale    <= pwdata;
        REG_Y_SCALE:    y_scale    <= pwdata;
        REG_GRID_ORDER: grid_order <= pwdata[ORDER_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_X_ORIGIN:   prdata = x_origin;
      REG_Y_ORIGIN:   prdata = y_origin;
      REG_X_SCALE:    prdata = x_scale;
      REG_Y_SCALE:    prdata = y_scale;
      REG_GRID_ORDER: prdata = APB_DATA_W'(grid_order);
      default:        prdata = '0;
    endcase
  end

  // Effective order: zero acts as one, anything above MAX_ORDER as MAX_ORDER.
  logic [OrderW-1:0]    order_eff;
  logic [MAX_ORDER-1:0] maxcell;
  logic                 swap;

  always_comb begin
    if (grid_order == '0) begin
      order_eff = OrderW'(1);
    end else if (grid_order > ORDER_CFG_W'(MAX_ORDER)) begin
      order_eff = OrderW'(MAX_ORDER);
    end else begin
      order_eff = OrderW'(grid_order);
    end
    for (int b = 0; b < MAX_ORDER; b++) begin
      maxcell[b] = OrderW'(b) < order_eff;
    end
  end

  // The curve runs all MAX_ORDER levels; an odd number of unused top levels
  // leaves x and y exchanged, which the curve undoes at its input.
  assign swap = MaxOdd ^ order_eff[0];

  // Stage control: a stage loads when it is empty or its successor loads.
  logic [NStages-1:0] vld;
  logic [NStages-1:0] en;

  always_comb begin
    en[NStages-1] = !vld[NStages-1] || m_tready;
    for (int i = NStages - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NStages; i++) begin
        if (en[i]) begin
          vld[i] <= (i == 0) ? s_tvalid : vld[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = vld[NStages-1];

  // Datapath.
  logic [MAX_ORDER-1:0]   cx;
  logic [MAX_ORDER-1:0]   cy;
  logic                   clamp_x;
  logic                   clamp_y;
  logic [2*MAX_ORDER-1:0] distance;
  logic                   clamped;

  qhi_cell #(.MAX_ORDER(MAX_ORDER)) u_cell_x (
    .clk      (clk),
    .en       (en[QUANT_STAGES-1:0]),
    .coord    (s_tdata[COORD_W-1:0]),
    .origin   (x_origin),
    .scale    (x_scale),
    .maxcell  (maxcell),
    .cell_idx (cx),
    .clamp    (clamp_x)
  );

  qhi_cell #(.MAX_ORDER(MAX_ORDER)) u_cell_y (
    .clk      (clk),
    .en       (en[QUANT_STAGES-1:0]),
    .coord    (s_tdata[2*COORD_W-1:COORD_W]),
    .origin   (y_origin),
    .scale    (y_scale),
    .maxcell  (maxcell),
    .cell_idx (cy),
    .clamp    (clamp_y)
  );

  qhi_curve #(.MAX_ORDER(MAX_ORDER)) u_curve (
    .clk      (clk),
    .en       (en[NStages-1:QUANT_STAGES]),
    .swap     (swap),
    .cx       (cx),
    .cy       (cy),
    .clamp_in (clamp_x || clamp_y),
    .distance (distance),
    .clamped  (clamped)
  );

  assign m_tdata = INDEX_W'(distance);
  assign m_tuser = clamped;

  // An empty output stage, or a ready receiver, must let a new item in.
  `QHI_ASSERT_IMPL(a_ready_when_out_empty, !m_tvalid, s_tready)
  `QHI_ASSERT_IMPL(a_ready_when_drained, m_tready, s_tready)
  // A completely full pipeline facing a stall must refuse input.
  `QHI_ASSERT_IMPL(a_full_blocks_input, (&vld) && !m_tready, !s_tready)
  // A held first stage keeps its item.
  `QHI_ASSERT_NEXT(a_held_stage_keeps_item, vld[0] && !en[0], vld[0])

endmodule
`default_nettype wire

>>> hdl/qhi_cell.sv
// One axis quantizer: origin subtract, scale multiply, saturate to the grid.
`default_nettype none
module qhi_cell #(
  parameter int MAX_ORDER = qhi_pkg::DEFAULT_MAX_ORDER
) (
  input  logic                            clk,
  input  logic [qhi_pkg::QUANT_STAGES-1:0] en,
  input  logic [qhi_pkg::COORD_W-1:0]     coord,
  input  logic [qhi_pkg::COORD_W-1:0]     origin,
  input  logic [qhi_pkg::SCALE_W-1:0]     scale,
  input  logic [MAX_ORDER-1:0]            maxcell,
  output logic [MAX_ORDER-1:0]            cell_idx,
  output logic                            clamp
);
  import qhi_pkg::*;

  logic [COORD_W:0]   diff;
  logic [COORD_W:0]   mag_w;
  logic               neg_a;
  logic [COORD_W-1:0] mag_a;
  logic [PROD_W-1:0]  prod;
  logic               neg_b;
  logic [HI_W-1:0]    hi_b;
  logic               over;

  // The difference is exact in 33 bits; its magnitude never exceeds 2^32-1.
  assign diff  = {coord[COORD_W-1], coord} - {origin[COORD_W-1], origin};
  assign mag_w = diff[COORD_W] ? ((COORD_W+1)'(0) - diff) : diff;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      neg_a <= diff[COORD_W];
      mag_a <= mag_w[COORD_W-1:0];
    end
  end

  assign prod = PROD_W'(mag_a) * PROD_W'(scale);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      neg_b <= neg_a;
      hi_b  <= prod[PROD_W-1:CELL_SHIFT];
    end
  end

  // A zero scale gives a zero product, so it needs no path of its own.
  assign over = hi_b > HI_W'(maxcell);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      if (neg_b) begin
        cell_idx <= '0;
        clamp    <= |hi_b;
      end else if (over) begin
        cell_idx <= maxcell;
        clamp    <= 1'b1;
      end else begin
        cell_idx <= hi_b[MAX_ORDER-1:0];
        clamp    <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/qhi_curve.sv
// Hilbert distance pipeline: a fixed number of curve levels per register stage.
`default_nettype none
module qhi_curve #(
  parameter int MAX_ORDER = qhi_pkg::DEFAULT_MAX_ORDER
) (
  input  logic clk,
  input  logic [(MAX_ORDER + qhi_pkg::LEVELS_PER_STAGE - 1) /
                qhi_pkg::LEVELS_PER_STAGE - 1:0] en,
  input  logic                   swap,
  input  logic [MAX_ORDER-1:0]   cx,
  input  logic [MAX_ORDER-1:0]   cy,
  input  logic                   clamp_in,
  output logic [2*MAX_ORDER-1:0] distance,
  output logic                   clamped
);
  import qhi_pkg::*;

  localparam int Stages = (MAX_ORDER + LEVELS_PER_STAGE - 1) / LEVELS_PER_STAGE;

  logic [MAX_ORDER-1:0]   xs [Stages];
  logic [MAX_ORDER-1:0]   ys [Stages];
  logic [2*MAX_ORDER-1:0] ds [Stages];
  logic                   cs [Stages];

  // Every level runs from the top bit down. Levels above the active order see
  // zero bits and only exchange x and y, so an odd count of them is undone by
  // exchanging the inputs up front.
  for (genvar j = 0; j < Stages; j++) begin : g_stage
    logic [MAX_ORDER-1:0]   x_in;
    logic [MAX_ORDER-1:0]   y_in;
    logic [2*MAX_ORDER-1:0] d_in;
    logic                   c_in;
    logic [MAX_ORDER-1:0]   x_nx;
    logic [MAX_ORDER-1:0]   y_nx;
    logic [2*MAX_ORDER-1:0] d_nx;

    if (j == 0) begin : g_head
      assign x_in = swap ? cy : cx;
      assign y_in = swap ? cx : cy;
      assign d_in = '0;
      assign c_in = clamp_in;
    end else begin : g_body
      assign x_in = xs[j-1];
      assign y_in = ys[j-1];
      assign d_in = ds[j-1];
      assign c_in = cs[j-1];
    end

    always_comb begin
      int                   k;
      logic                 rx;
      logic                 ry;
      logic [MAX_ORDER-1:0] lo;
      logic [MAX_ORDER-1:0] tmp;
      k    = 0;
      rx   = 1'b0;
      ry   = 1'b0;
      lo   = '0;
      tmp  = '0;
      x_nx = x_in;
      y_nx = y_in;
      d_nx = d_in;
      for (int t = 0; t < LEVELS_PER_STAGE; t++) begin
        if (j * LEVELS_PER_STAGE + t < MAX_ORDER) begin
          k  = MAX_ORDER - 1 - (j * LEVELS_PER_STAGE + t);
          rx = x_nx[k];
          ry = y_nx[k];
          lo = {MAX_ORDER{1'b1}} >> (MAX_ORDER - k);
          d_nx[2*k +: 2] = {rx, rx ^ ry};
          x_nx = x_nx & lo;
          y_nx = y_nx & lo;
          if (!ry) begin
            if (rx) begin
              x_nx = x_nx ^ lo;
              y_nx = y_nx ^ lo;
            end
            tmp  = x_nx;
            x_nx = y_nx;
            y_nx = tmp;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        xs[j] <= x_nx;
        ys[j] <= y_nx;
        ds[j] <= d_nx;
        cs[j] <= c_in;
      end
    end
  end

  assign distance = ds[Stages-1];
  assign clamped  = cs[Stages-1];

endmodule
`default_nettype wire

>>> tb/tb_quantized_hilbert_index.sv
// Self-checking testbench for the quantized Hilbert index block.
module tb_quantized_hilbert_index;
  timeunit 1ns;
  timeprecision 1ps;
  import qhi_pkg::*;

  // Largest grid order the block is built for; larger settings are clipped to it.
  localparam int GRID_MAX = DEFAULT_MAX_ORDER;
  // A byte address that no register decodes; writes there must change nothing.
  localparam logic [APB_ADDR_W-1:0] UNUSED_ADDR = 5'd20;
  // The pipeline is seven stages deep; this leaves a margin after the last result.
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_POINTS = 70;
  // 1.0 in Q16.16.
  localparam logic [31:0] ONE = 32'h0001_0000;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic               clamped;
  } cell_result_t;

  // Keeps a copy of the block's registers, predicts the result of every accepted
  // point and checks the results in order against those predictions.
  class hilbert_scoreboard;
    logic [31:0]    x_origin, y_origin, x_scale, y_scale;
    logic [4:0]     grid_order;
    cell_result_t   expected_q[$];
    int             mismatches;

    function new();
      x_origin   = X_ORIGIN_RST;
      y_origin   = Y_ORIGIN_RST;
      x_scale    = X_SCALE_RST;
      y_scale    = Y_SCALE_RST;
      grid_order = GRID_ORDER_RST;
      mismatches = 0;
    endfunction

    function void write_reg(logic [APB_ADDR_W-1:0] addr, logic [31:0] data);
      case (addr[APB_ADDR_W-1:2])
        REG_X_ORIGIN:   x_origin = data;
        REG_Y_ORIGIN:   y_origin = data;
        REG_X_SCALE:    x_scale = data;
        REG_Y_SCALE:    y_scale = data;
        REG_GRID_ORDER: grid_order = data[4:0];
        default: ;
      endcase
    endfunction

    // Cell index of one axis. The product of the exact difference and the scale
    // is formed in 64 bits; its upper half is the cell.
    function logic [31:0] axis_cell(input logic [31:0] coord, origin, scale, maxcell,
                                    inout bit clamp);
      longint          diff;
      longint unsigned mag, cell_idx;
      diff = longint'($signed(coord)) - longint'($signed(origin));
      if (scale == 0) return '0;
      mag = (diff < 0) ? longint'(-diff) : diff;
      cell_idx = (mag * longint'({32'b0, scale})) >> 32;
      if (diff < 0) begin
        // Less than one cell below the origin rounds to cell 0 without saturating.
        if (cell_idx != 0) clamp = 1'b1;
        return '0;
      end
      if (cell_idx > maxcell) begin
        clamp = 1'b1;
        return maxcell;
      end
      return cell_idx[31:0];
    endfunction

    // Distance along the Hilbert curve, walking from the top level down and
    // rotating the remaining quadrant as the curve does.
    function logic [31:0] curve_distance(int unsigned order, logic [31:0] x, logic [31:0] y);
      int unsigned s, rx, ry, lo, d;
      logic [31:0] t;
      d = 0;
      s = 1 << (order - 1);
      while (s > 0) begin
        rx = ((x & s) != 0) ? 1 : 0;
        ry = ((y & s) != 0) ? 1 : 0;
        lo = s - 1;
        d += s * s * ((3 * rx) ^ ry);
        x &= lo;
        y &= lo;
        if (ry == 0) begin
          if (rx == 1) begin
            x = lo - x;
            y = lo - y;
          end
          t = x;
          x = y;
          y = t;
        end
        s >>= 1;
      end
      return d;
    endfunction

    function void note_point(logic [31:0] x, logic [31:0] y);
      int unsigned  order;
      logic [31:0]  maxcell, cx, cy;
      bit           clamp;
      cell_result_t r;
      order = grid_order;
      if (order < 1) order = 1;
      if (order > GRID_MAX) order = GRID_MAX;
      maxcell = 32'((64'd1 << order) - 1);
      clamp = 1'b0;
      cx = axis_cell(x, x_origin, x_scale, maxcell, clamp);
      cy = axis_cell(y, y_origin, y_scale, maxcell, clamp);
      r.index = curve_distance(order, cx, cy);
      r.clamped = clamp;
      expected_q = {expected_q, r};
    endfunction

    function void check_result(logic [31:0] index, logic clamped);
      cell_result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no point pending: index %h clamped %b",
                   $realtime, index, clamped);
        return;
      end
      want = expected_q.pop_front();
      if (want.index !== index || want.clamped !== clamped) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch: index expected %h got %h, clamped expected %b got %b",
                   $realtime, want.index, index, want.clamped, clamped);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  // All inputs of the block start at known values.
  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [2*COORD_W-1:0]    s_tdata = '0;   // x_coord [31:0], y_coord [63:32]
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [INDEX_W-1:0]      m_tdata;        // hilbert_index [31:0]
  logic                    m_tuser;        // clamped [0]
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]   paddr = '0;
  logic [APB_DATA_W-1:0]   pwdata = '0;
  logic [APB_DATA_W-1:0]   prdata;
  logic                    pready;

  // Set for the last phase: neither side idles from then on.
  bit calm = 1'b0;

  hilbert_scoreboard sb = new();

  quantized_hilbert_index dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Every result accepted at a rising edge is compared with the oldest prediction.
  // Signals read here still hold their values from before the edge, since all of
  // them are updated by nonblocking assignments.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
  end

  // The receiver alternates at random between ready stretches and stalls,
  // and stays ready once the final phase has begun.
  initial begin
    forever begin
      if (calm) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // One register write: a setup phase, then an access phase that ends at the edge
  // where pready is seen high, then an idle phase with psel low so that back-to-back
  // writes never drive psel twice in one step.
  task automatic reg_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(addr, data);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [31:0] xo, yo, xs, ys, input logic [4:0] ord);
    reg_write({REG_X_ORIGIN, 2'b00}, xo);
    reg_write({REG_Y_ORIGIN, 2'b00}, yo);
    reg_write({REG_X_SCALE, 2'b00}, xs);
    reg_write({REG_Y_SCALE, 2'b00}, ys);
    reg_write({REG_GRID_ORDER, 2'b00}, {27'b0, ord});
  endtask

  // Offers one point and returns at the edge where it is accepted, with tvalid
  // still high so the next point can follow without a bubble. Outside the final
  // phase a gap is sometimes put in first. The prediction is made here, so it is
  // in place before the caller looks at the queue.
  task automatic send_point(input logic [31:0] x, input logic [31:0] y);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {y, x};
    do @(posedge clk); while (!s_tready);
    sb.note_point(x, y);
  endtask

  // Ends a phase: waits for every predicted result, then lets the pipeline settle
  // so that a stray late result would still be seen before registers change.
  task automatic finish_phase();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return ONE;
      2: return 32'hFFFF_FFFF;
      3: return $urandom_range(1, 32'h0000_FFFF);     // less than one cell per unit
      4: return $urandom_range(32'h0001_0000, 32'h0100_0000);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_origin();
    if ($urandom_range(0, 1) == 0) return $urandom();
    return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
  endfunction

  // A coordinate that mostly lands inside the grid of one axis: the offset from
  // the origin is drawn from the range that maps to cells 0 .. 2^order, with some
  // points pushed just below the origin or right at the upper edge.
  function automatic logic [31:0] near_coord(logic [31:0] origin, logic [31:0] scale,
                                             int unsigned order);
    longint unsigned span;
    if (scale == 0) span = 64'hFFFF_FFFF;
    else span = (64'd1 << (order + 32)) / scale;
    if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
    case ($urandom_range(0, 7))
      0: return origin - $urandom_range(1, 32'h0002_0000);
      1: return origin + 32'(span) - $urandom_range(0, 3);
      default: return origin + $urandom_range(0, 32'(span));
    endcase
  endfunction

  // One random phase: a new register setting, then a run of points. The first two
  // phases take the largest and the smallest grid order; later ones sometimes use
  // out-of-range orders that the block has to clip.
  task automatic random_phase(input int p);
    logic [31:0] xo, yo, xs, ys, x, y;
    logic [4:0]  ord;
    int unsigned eff;
    if (p == 0) ord = 5'd16;
    else if (p == 1) ord = 5'd1;
    else if ($urandom_range(0, 4) == 0)
      ord = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(17, 31));
    else ord = 5'($urandom_range(1, 16));
    xo = pick_origin();
    yo = pick_origin();
    xs = pick_scale();
    ys = pick_scale();
    configure(xo, yo, xs, ys, ord);
    eff = (ord == 0) ? 1 : (ord > GRID_MAX) ? GRID_MAX : ord;
    repeat (PHASE_POINTS) begin
      if ($urandom_range(0, 3) == 0) begin
        x = $urandom();
        y = $urandom();
      end else begin
        x = near_coord(xo, xs, eff);
        y = near_coord(yo, ys, eff);
      end
      send_point(x, y);
    end
    finish_phase();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset setting: origin 0, scale 1.0, a 2x2 grid. The four cells in curve
    // order, a fraction just under one cell, a point less than a cell below the
    // origin, one a full cell below, one past the grid, and the coordinate extremes.
    send_point(32'h0, 32'h0);
    send_point(32'h0, ONE);
    send_point(ONE, ONE);
    send_point(ONE, 32'h0);
    send_point(32'h0000_FFFF, 32'h0000_FFFF);
    send_point(32'hFFFF_8000, 32'h0);
    send_point(32'hFFFF_0000, 32'h0);
    send_point(32'h0002_0000, ONE);
    send_point(32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    finish_phase();

    // A write to an address with no register behind it must leave the setting alone.
    reg_write(UNUSED_ADDR, 32'hFFFF_FFFF);
    send_point(ONE, 32'h0);
    finish_phase();

    // Origins at the extremes, the largest x scale and a zero y scale: x sees the
    // widest difference there is, while y collapses to cell 0 without saturating.
    configure(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 5'd16);
    send_point(32'h7FFF_FFFF, 32'h1234_5678);
    send_point(32'h8000_0000, 32'h8000_0000);
    send_point(32'h8000_0001, 32'h0);
    finish_phase();

    // A grid order of zero behaves as one.
    configure(32'h0, 32'h0, ONE, ONE, 5'd0);
    send_point(ONE, ONE);
    send_point(ONE, 32'h0);
    finish_phase();

    // An order above the maximum behaves as the maximum; at scale 2.0 the largest
    // coordinate lands exactly on the last cell.
    configure(32'h0, 32'h0, 32'h0002_0000, 32'h0002_0000, 5'd31);
    send_point(32'h7FFF_FFFF, 32'h0);
    send_point(32'h0, 32'h7FFF_FFFF);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    finish_phase();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == RANDOM_PHASES - 1) calm = 1'b1;
      random_phase(p);
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_quantized_hilbert_index: clean");
    end else begin
      $display("tb_quantized_hilbert_index: errors");
    end
    $finish;
  end

  // Far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("tb_quantized_hilbert_index: errors");
    $finish;
  end

endmodule
